[rtl/natpt_pkg.sv]
// Shared types and constants for the port translation table.
`default_nettype none

package natpt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int PORT_W  = 16;
   localparam int ADDR_W  = 32;
   localparam int PROTO_W = 8;

   localparam logic [PORT_W-1:0] PORT_BASE_RESET = 16'd40000;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_MATCH = 2'd2
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  priv_addr;
      logic [PORT_W-1:0]  lan_port;
      logic [PORT_W-1:0]  wan_port;
      logic [ADDR_W-1:0]  rem_addr;
      logic [PORT_W-1:0]  rem_port;
      logic [PROTO_W-1:0] proto;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic load;
      logic alloc;
      logic scan;
      logic scan_end;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_inbound;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[rtl/natpt_ram.sv]
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module natpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/natpt_ctrl.sv]
// Sequencer for allocate, scan and result hand-off.
`default_nettype none

module natpt_ctrl import natpt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire sts_type sts,
   output      cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               state_in = sts.req_inbound ? ST_SCAN : ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               cmd.scan_end = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

   // ready only while idle
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> state_ff == ST_IDLE)
      else $error("req_ready outside idle");

   // accepted beat leaves idle on the next edge
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff != ST_IDLE && !req_ready_ff)
      else $error("accepted beat did not start work");

   // an allocate is followed by finish on the next edge
   a_alloc_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ALLOC |=> state_ff == ST_FINISH)
      else $error("allocate took more than one cycle");

endmodule

`default_nettype wire

[rtl/natpt_dp.sv]
// Datapath: request capture, entry table, scan compare and result registers.
`default_nettype none

module natpt_dp import natpt_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output      sts_type             sts,
   input  wire logic                req_kind,
   input  wire logic [ADDR_W-1:0]   req_local_addr,
   input  wire logic [PORT_W-1:0]   req_local_port,
   input  wire logic [ADDR_W-1:0]   req_remote_addr,
   input  wire logic [PORT_W-1:0]   req_remote_port,
   input  wire logic [PROTO_W-1:0]  req_protocol,
   input  wire logic [PORT_W-1:0]   req_wan_port,
   input  wire logic                csr_valid,
   input  wire logic [PORT_W-1:0]   csr_port_base,
   input  wire logic                rsp_ready,
   output      logic                rsp_valid,
   output      logic [1:0]          rsp_status,
   output      logic [PORT_W-1:0]   rsp_assigned_port,
   output      logic [ADDR_W-1:0]   rsp_private_addr,
   output      logic [PORT_W-1:0]   rsp_lan_port
);

   // control registers
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PORT_W-1:0] port_base_ff, port_base_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   entry_type         req_ff, req_in;
   logic [CNT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   status_type        res_status_ff, res_status_in;
   logic [PORT_W-1:0] res_port_ff, res_port_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [PORT_W-1:0] res_pport_ff, res_pport_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [PORT_W-1:0] rsp_pport_ff, rsp_pport_in;

   logic              full;
   logic [PORT_W-1:0] assigned;
   logic              wr_en;
   entry_type         wr_entry;
   logic [ENTRY_W-1:0] rd_data;
   entry_type         rd_entry;
   logic              match;
   logic              hit;
   logic              out_free;

   assign full     = (count_ff == CNT_W'(TABLE_ENTRIES));
   assign assigned = port_base_ff + PORT_W'(count_ff);
   assign wr_en    = cmd.alloc && !full;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_entry          = req_ff;
      wr_entry.wan_port = assigned;
   end

   natpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);

   // req_ff.wan_port holds the public port to translate on inbound beats
   assign match = (rd_entry.wan_port == req_ff.wan_port) &&
                  (rd_entry.rem_addr == req_ff.rem_addr) &&
                  (rd_entry.rem_port == req_ff.rem_port) &&
                  (rd_entry.proto    == req_ff.proto);
   assign hit   = cmp_vld_ff && match;

   always_comb begin
      sts.req_inbound = req_kind;
      sts.out_free    = out_free;
      sts.scan_done   = (count_ff == '0) ||
                        (cmp_vld_ff && (match || ((cmp_idx_ff + CNT_W'(1)) == count_ff)));
   end

   always_comb begin
      count_in     = count_ff;
      port_base_in = port_base_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;

      if (csr_valid) begin
         port_base_in = csr_port_base;
      end
      if (cmd.load) begin
         scan_idx_in = '0;
         cmp_vld_in  = 1'b0;
      end
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
         cmp_vld_in  = (scan_idx_ff < count_ff);
         cmp_idx_in  = scan_idx_ff;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      req_in        = req_ff;
      res_status_in = res_status_ff;
      res_port_in   = res_port_ff;
      res_addr_in   = res_addr_ff;
      res_pport_in  = res_pport_ff;
      rsp_status_in = rsp_status_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pport_in  = rsp_pport_ff;

      if (cmd.load) begin
         req_in.priv_addr = req_local_addr;
         req_in.lan_port  = req_local_port;
         req_in.wan_port  = req_wan_port;
         req_in.rem_addr  = req_remote_addr;
         req_in.rem_port  = req_remote_port;
         req_in.proto     = req_protocol;
      end
      if (cmd.alloc) begin
         res_status_in = full ? STATUS_FULL : STATUS_OK;
         res_port_in   = full ? '0 : assigned;
         res_addr_in   = '0;
         res_pport_in  = '0;
      end
      if (cmd.scan_end) begin
         res_status_in = hit ? STATUS_OK : STATUS_NO_MATCH;
         res_port_in   = '0;
         res_addr_in   = hit ? rd_entry.priv_addr : '0;
         res_pport_in  = hit ? rd_entry.lan_port : '0;
      end
      if (cmd.emit) begin
         rsp_status_in = res_status_ff;
         rsp_port_in   = res_port_ff;
         rsp_addr_in   = res_addr_ff;
         rsp_pport_in  = res_pport_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         port_base_ff <= PORT_BASE_RESET;
         scan_idx_ff  <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         port_base_ff <= port_base_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_port_ff   <= res_port_in;
      res_addr_ff   <= res_addr_in;
      res_pport_ff  <= res_pport_in;
      rsp_status_ff <= rsp_status_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pport_ff  <= rsp_pport_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_assigned_port = rsp_port_ff;
   assign rsp_private_addr  = rsp_addr_ff;
   assign rsp_lan_port      = rsp_pport_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   a_alloc_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("allocate did not append an entry");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> cmp_idx_ff < count_ff)
      else $error("compare on an unwritten entry");

endmodule

`default_nettype wire

[rtl/nat_port_translation_table_core.sv]
// Top level of the NAT port translation table.
//
//  channel | direction | beat contents
//  req_    | in        | kind, local/remote address and port, protocol, public port
//  rsp_    | out       | status, assigned port, private address and port
//  csr_    | in        | port_base write data
//
// Outbound beat: accept, append in the allocate state, then hand-off to the output register.
// Inbound beat: the scan reads one entry per cycle from the table RAM through its
// single read port.
// Reset clears the table count and loads port_base with 40000.
// A result waiting in the output register does not block the next accept;
// it only holds the following result until taken.
`default_nettype none

module nat_port_translation_table_core import natpt_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_kind,
   input  wire logic [ADDR_W-1:0]   req_local_addr,
   input  wire logic [PORT_W-1:0]   req_local_port,
   input  wire logic [ADDR_W-1:0]   req_remote_addr,
   input  wire logic [PORT_W-1:0]   req_remote_port,
   input  wire logic [PROTO_W-1:0]  req_protocol,
   input  wire logic [PORT_W-1:0]   req_wan_port,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [1:0]          rsp_status,
   output      logic [PORT_W-1:0]   rsp_assigned_port,
   output      logic [ADDR_W-1:0]   rsp_private_addr,
   output      logic [PORT_W-1:0]   rsp_lan_port,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [PORT_W-1:0]   csr_port_base
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   natpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   natpt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_local_addr    (req_local_addr),
      .req_local_port    (req_local_port),
      .req_remote_addr   (req_remote_addr),
      .req_remote_port   (req_remote_port),
      .req_protocol      (req_protocol),
      .req_wan_port      (req_wan_port),
      .csr_valid         (csr_valid),
      .csr_port_base     (csr_port_base),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_assigned_port (rsp_assigned_port),
      .rsp_private_addr  (rsp_private_addr),
      .rsp_lan_port      (rsp_lan_port)
   );

endmodule

`default_nettype wire

[bench/nat_port_translation_table_core_tb.sv]
// Self-checking testbench for the NAT port translation table core.
`default_nettype none

module nat_port_translation_table_core_tb;
   import natpt_pkg::*;

   localparam logic KIND_OUTBOUND = 1'b0;
   localparam logic KIND_INBOUND  = 1'b1;
   localparam int   CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  local_addr;
      logic [PORT_W-1:0]  local_port;
      logic [ADDR_W-1:0]  remote_addr;
      logic [PORT_W-1:0]  remote_port;
      logic [PROTO_W-1:0] protocol;
      logic [PORT_W-1:0]  wan_port;
   } napt_req_type;

   typedef struct packed {
      status_type         status;
      logic [PORT_W-1:0]  assigned_port;
      logic [ADDR_W-1:0]  private_addr;
      logic [PORT_W-1:0]  lan_port;
   } napt_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_kind = KIND_OUTBOUND;
   logic [ADDR_W-1:0]   req_local_addr = '0;
   logic [PORT_W-1:0]   req_local_port = '0;
   logic [ADDR_W-1:0]   req_remote_addr = '0;
   logic [PORT_W-1:0]   req_remote_port = '0;
   logic [PROTO_W-1:0]  req_protocol = '0;
   logic [PORT_W-1:0]   req_wan_port = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [PORT_W-1:0]   rsp_assigned_port;
   logic [ADDR_W-1:0]   rsp_private_addr;
   logic [PORT_W-1:0]   rsp_lan_port;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PORT_W-1:0]   csr_port_base = '0;

   // translation state as the block should hold it
   entry_type           xlat_table [TABLE_ENTRIES];
   int unsigned         entry_count;
   logic [PORT_W-1:0]   port_base;
   logic [PORT_W-1:0]   next_public;

   napt_rsp_type        translations_due [$];
   napt_rsp_type        oldest_due;

   int                  errors = 0;
   int                  beats_sent = 0;
   int                  results_seen = 0;
   int                  full_refusals = 0;
   int                  lookup_hits = 0;
   int                  csr_writes = 0;
   int                  cycle_count = 0;

   bit                  sender_idles = 1'b1;
   bit                  receiver_idles = 1'b1;
   int                  rsp_hold_req = 0;
   int                  rsp_hold = 0;
   int                  rsp_stall_left = 0;

   nat_port_translation_table_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_local_addr    (req_local_addr),
      .req_local_port    (req_local_port),
      .req_remote_addr   (req_remote_addr),
      .req_remote_port   (req_remote_port),
      .req_protocol      (req_protocol),
      .req_wan_port      (req_wan_port),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_assigned_port (rsp_assigned_port),
      .rsp_private_addr  (rsp_private_addr),
      .rsp_lan_port      (rsp_lan_port),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_port_base     (csr_port_base)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, translations_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   function automatic napt_rsp_type napt_translate(input napt_req_type beat);
      napt_rsp_type r;
      bit           found;
      r = '0;
      r.status = STATUS_OK;
      found = 1'b0;
      if (beat.kind == KIND_OUTBOUND) begin
         if (entry_count >= TABLE_ENTRIES) begin
            r.status = STATUS_FULL;
            full_refusals++;
         end else begin
            xlat_table[entry_count] = '{beat.local_addr, beat.local_port, next_public,
                                        beat.remote_addr, beat.remote_port, beat.protocol};
            r.assigned_port = next_public;
            entry_count++;
            next_public = next_public + 16'd1;
         end
      end else begin
         for (int i = 0; i < entry_count; i++) begin
            if (!found && xlat_table[i].wan_port == beat.wan_port &&
                xlat_table[i].rem_addr == beat.remote_addr &&
                xlat_table[i].rem_port == beat.remote_port &&
                xlat_table[i].proto == beat.protocol) begin
               found = 1'b1;
               r.private_addr = xlat_table[i].priv_addr;
               r.lan_port     = xlat_table[i].lan_port;
            end
         end
         if (found) begin
            lookup_hits++;
         end else begin
            r.status = STATUS_NO_MATCH;
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (translations_due.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual status %0d",
                     $time, rsp_status);
            errors++;
         end else begin
            oldest_due = translations_due.pop_front();
            check_field("status", 32'(oldest_due.status), 32'(rsp_status));
            check_field("assigned_port", 32'(oldest_due.assigned_port), 32'(rsp_assigned_port));
            check_field("private_addr", oldest_due.private_addr, rsp_private_addr);
            check_field("lan_port", 32'(oldest_due.lan_port), 32'(rsp_lan_port));
         end
      end
   end

   // result side: long hold on request, else random stall bursts while receiver_idles is set
   always @(negedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
         rsp_stall_left = $urandom_range(1, 19) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(input napt_req_type beat);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_kind        <= beat.kind;
      req_local_addr  <= beat.local_addr;
      req_local_port  <= beat.local_port;
      req_remote_addr <= beat.remote_addr;
      req_remote_port <= beat.remote_port;
      req_protocol    <= beat.protocol;
      req_wan_port    <= beat.wan_port;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      translations_due.push_back(napt_translate(beat));
      beats_sent++;
   endtask

   task automatic req_release();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_port_base(input logic [PORT_W-1:0] value);
      req_release();
      while (translations_due.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_port_base <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      port_base   = value;
      next_public = value + PORT_W'(entry_count);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic napt_req_type rand_outbound();
      napt_req_type beat;
      beat.kind        = KIND_OUTBOUND;
      beat.local_addr  = $urandom;
      beat.local_port  = 16'($urandom);
      beat.remote_addr = $urandom;
      beat.remote_port = 16'($urandom);
      beat.protocol    = 8'($urandom);
      beat.wan_port    = 16'($urandom);
      return beat;
   endfunction

   // mostly keys of stored entries, some with one bit flipped, some pure noise
   function automatic napt_req_type rand_lookup();
      napt_req_type beat;
      int           idx;
      beat = rand_outbound();
      beat.kind = KIND_INBOUND;
      if (entry_count > 0 && $urandom_range(0, 4) != 0) begin
         idx = $urandom_range(0, entry_count - 1);
         beat.wan_port    = xlat_table[idx].wan_port;
         beat.remote_addr = xlat_table[idx].rem_addr;
         beat.remote_port = xlat_table[idx].rem_port;
         beat.protocol    = xlat_table[idx].proto;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: beat.wan_port ^= 16'h1 << $urandom_range(0, 15);
               1: beat.remote_addr ^= 32'h1 << $urandom_range(0, 31);
               2: beat.remote_port ^= 16'h1 << $urandom_range(0, 15);
               default: beat.protocol ^= 8'h1 << $urandom_range(0, 7);
            endcase
         end
      end
      return beat;
   endfunction

   function automatic napt_req_type key_of(input int idx);
      napt_req_type beat;
      beat = rand_outbound();
      beat.kind        = KIND_INBOUND;
      beat.wan_port    = xlat_table[idx].wan_port;
      beat.remote_addr = xlat_table[idx].rem_addr;
      beat.remote_port = xlat_table[idx].rem_port;
      beat.protocol    = xlat_table[idx].proto;
      return beat;
   endfunction

   task automatic test_reset_base();
      napt_req_type beat;
      beat = rand_outbound();
      beat.protocol = 8'd6;
      send_beat(beat);
      req_release();
   endtask

   task automatic test_port_wrap();
      write_port_base(16'd65534);
      send_beat(rand_outbound());
      send_beat(rand_outbound());
      req_release();
   endtask

   task automatic test_field_extremes();
      napt_req_type beat;
      write_port_base(16'd0);
      beat = '1;
      beat.kind = KIND_OUTBOUND;
      send_beat(beat);
      beat = '0;
      send_beat(beat);
      beat = key_of(entry_count - 2);
      beat.local_addr = '0;
      beat.local_port = '0;
      send_beat(beat);
      beat = key_of(entry_count - 1);
      beat.local_addr = '1;
      beat.local_port = '1;
      send_beat(beat);
      req_release();
   endtask

   task automatic test_lookup_misses();
      napt_req_type beat;
      send_beat(key_of(0));
      beat = key_of(0);
      beat.wan_port ^= 16'h8000;
      send_beat(beat);
      beat = key_of(0);
      beat.remote_addr ^= 32'h0000_0100;
      send_beat(beat);
      beat = key_of(0);
      beat.remote_port ^= 16'h0001;
      send_beat(beat);
      beat = key_of(0);
      beat.protocol ^= 8'h80;
      send_beat(beat);
      send_beat(key_of(2));
      req_release();
   endtask

   task automatic test_duplicate_key();
      napt_req_type beat;
      // rebase so the next allocation reuses entry 0's public port
      write_port_base(xlat_table[0].wan_port - PORT_W'(entry_count));
      beat = rand_outbound();
      beat.remote_addr = xlat_table[0].rem_addr;
      beat.remote_port = xlat_table[0].rem_port;
      beat.protocol    = xlat_table[0].proto;
      send_beat(beat);
      send_beat(key_of(0));
      req_release();
   endtask

   task automatic test_output_backpressure();
      sender_idles = 1'b0;
      @(posedge clock);
      rsp_hold_req = 300;
      repeat (24) begin
         send_beat(rand_lookup());
      end
      req_release();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_traffic(input int count, input bit with_idles);
      sender_idles   = with_idles;
      receiver_idles = with_idles;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            send_beat(rand_outbound());
         end else begin
            send_beat(rand_lookup());
         end
      end
      req_release();
   endtask

   task automatic test_table_full();
      napt_req_type beat;
      while (entry_count < TABLE_ENTRIES) begin
         send_beat(rand_outbound());
      end
      send_beat(rand_outbound());
      write_port_base(16'd65535);
      beat = '1;
      beat.kind = KIND_OUTBOUND;
      send_beat(beat);
      send_beat(key_of(TABLE_ENTRIES - 1));
      req_release();
   endtask

   initial begin
      entry_count = 0;
      port_base   = PORT_BASE_RESET;
      next_public = PORT_BASE_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_base();
      test_port_wrap();
      test_field_extremes();
      test_lookup_misses();
      test_duplicate_key();
      test_output_backpressure();
      write_port_base(16'($urandom));
      test_random_traffic(120, 1'b1);
      write_port_base(16'd0);
      test_random_traffic(120, 1'b1);
      test_table_full();
      write_port_base(16'($urandom));
      test_random_traffic(120, 1'b1);
      write_port_base(16'd65535);
      test_random_traffic(120, 1'b1);
      write_port_base(16'($urandom));
      test_random_traffic(150, 1'b0);

      while (translations_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);
      $display("Sent %0d request beats (%0d lookup hits, %0d table-full refusals),",
               beats_sent, lookup_hits, full_refusals);
      $display("checked %0d results across %0d port_base writes.", results_seen, csr_writes);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
rtl/natpt_pkg.sv
rtl/natpt_ram.sv
rtl/natpt_ctrl.sv
rtl/natpt_dp.sv
rtl/nat_port_translation_table_core.sv
bench/nat_port_translation_table_core_tb.sv
